### hdl/bprg_pkg.sv
package bprg_pkg;

  localparam int TICK_W       = 31;
  localparam int USER_W       = 64;
  localparam int WIN_W        = 10;
  localparam int MAXP_W       = 5;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 10;
  localparam int IN_TDATA_W   = 96;
  localparam int OUT_TDATA_W  = 8;

  localparam int MAX_TRACKED_DEF = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_GUARD_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TICKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PRESSES  = 2'd2;

  localparam logic              GUARD_ENABLE_RST = 1'b1;
  localparam logic [WIN_W-1:0]  WINDOW_TICKS_RST = 10'd75;
  localparam logic [MAXP_W-1:0] MAX_PRESSES_RST  = 5'd5;

  typedef struct packed {
    logic load_in;
    logic eval;
    logic scan;
    logic commit;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_done;
    logic out_free;
  } ctrl_sts_t;

endpackage

### hdl/button_press_rate_guard_core.sv
// Button press rate guard.
// Commands enter on the in_ channel, one transfer per server tick, and each
// command yields exactly one result transfer on the out_ channel, in order.
// The guard passes the button level through but holds it low until release
// when a new press would exceed max_presses (capped at MAX_TRACKED) accepted
// presses within the last window_ticks ticks. Exempt commands pass untouched.
// The configuration port writes guard_enable, window_ticks and max_presses;
// write it only while no command is in flight.
// Each command is loaded in IDLE and evaluated in EVAL. Releases, held
// buttons, exempt commands and a disabled guard then go straight to EMIT,
// which writes the output register. A new press first passes SCAN, a
// compaction sweep over the stored press times (at most MAX_TRACKED), one
// entry a cycle through the memory's single read port, and then COMMIT,
// which stores the press or blocks it, before EMIT.
// A new command is taken once the previous result sits in the output register,
// so the next command starts even while the receiver stalls; a stalled result
// is held until taken, and the next command waits in EMIT, stalling the input.
// Reset (rst_n low, synchronous) clears the guard state and loads the
// register defaults: guard enabled, a 75-tick window and five presses.
module button_press_rate_guard_core #(
  parameter int MAX_TRACKED = bprg_pkg::MAX_TRACKED_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // tick[30:0], user_id[94:31], button_down[95]
  input  logic [bprg_pkg::IN_TDATA_W-1:0]      in_tdata,
  // exempt[0]
  input  logic                                 in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // button_out[0], suppressed[1], zero fill [7:2]
  output logic [bprg_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  logic                                 cfg_we,
  input  logic [bprg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bprg_pkg::CFG_DATA_W-1:0]      cfg_data
);

  logic                           guard_enable_r;
  logic [bprg_pkg::WIN_W-1:0]     window_ticks_r;
  logic [bprg_pkg::MAXP_W-1:0]    max_presses_r;
  bprg_pkg::ctrl_cmd_t            cmd;
  bprg_pkg::ctrl_sts_t            sts;
  logic                           btn_out;
  logic                           sup_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      guard_enable_r <= bprg_pkg::GUARD_ENABLE_RST;
      window_ticks_r <= bprg_pkg::WINDOW_TICKS_RST;
      max_presses_r  <= bprg_pkg::MAX_PRESSES_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bprg_pkg::CFG_GUARD_ENABLE: guard_enable_r <= cfg_data[0];
        bprg_pkg::CFG_WINDOW_TICKS: window_ticks_r <= cfg_data[bprg_pkg::WIN_W-1:0];
        bprg_pkg::CFG_MAX_PRESSES:  max_presses_r  <= cfg_data[bprg_pkg::MAXP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  bprg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bprg_dp #(
    .MAX_TRACKED (MAX_TRACKED)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .guard_enable   (guard_enable_r),
    .window_ticks   (window_ticks_r),
    .max_presses    (max_presses_r),
    .in_tick        (in_tdata[30:0]),
    .in_user_id     (in_tdata[94:31]),
    .in_exempt      (in_tuser),
    .in_button_down (in_tdata[95]),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_button_out (btn_out),
    .out_suppressed (sup_out)
  );

  assign out_tdata = {6'b0, sup_out, btn_out};

endmodule

### hdl/bprg_ctrl.sv
module bprg_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bprg_pkg::ctrl_sts_t sts,
  output bprg_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_EVAL   = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_COMMIT = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    in_ready    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
        if (in_valid) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = sts.need_scan ? ST_SCAN : ST_EMIT;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit = sts.out_free;
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### hdl/bprg_dp.sv
module bprg_dp #(
  parameter int MAX_TRACKED = bprg_pkg::MAX_TRACKED_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            guard_enable,
  input  logic [bprg_pkg::WIN_W-1:0]      window_ticks,
  input  logic [bprg_pkg::MAXP_W-1:0]     max_presses,
  input  logic [bprg_pkg::TICK_W-1:0]     in_tick,
  input  logic [bprg_pkg::USER_W-1:0]     in_user_id,
  input  logic                            in_exempt,
  input  logic                            in_button_down,
  input  bprg_pkg::ctrl_cmd_t             cmd,
  output bprg_pkg::ctrl_sts_t             sts,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_button_out,
  output logic                            out_suppressed
);

  localparam int CNT_W = $clog2(MAX_TRACKED + 1);
  localparam int IDX_W = (MAX_TRACKED > 1) ? $clog2(MAX_TRACKED) : 1;
  localparam int CMP_W = (CNT_W > bprg_pkg::MAXP_W) ? CNT_W : bprg_pkg::MAXP_W;
  localparam int TW    = bprg_pkg::TICK_W;
  localparam int WIN_W_L = bprg_pkg::WIN_W;

  logic [TW-1:0]               tick_r;
  logic [bprg_pkg::USER_W-1:0] user_r;
  logic                        exempt_r;
  logic                        down_r;

  logic [CNT_W-1:0]            count_r, count_nxt;
  logic [TW-1:0]               last_tick_r, last_tick_nxt;
  logic [bprg_pkg::USER_W-1:0] last_user_r, last_user_nxt;
  logic                        held_r, held_nxt;
  logic                        block_r, block_nxt;
  logic [CNT_W-1:0]            rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0]            kept_r, kept_nxt;
  logic                        cmp_vld_r, cmp_vld_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        res_btn_r, res_btn_nxt;
  logic                        res_sup_r, res_sup_nxt;
  logic                        obtn_r, osup_r;

  logic [TW-1:0]               press_times_r [MAX_TRACKED];
  logic [TW-1:0]               rdata_r;

  logic                        clr;
  logic                        held_eff;
  logic                        block_eff;
  logic                        rd_go;
  logic [TW:0]                 age;
  logic                        keep;
  logic [WIN_W_L-1:0]          win_eff;
  logic [CMP_W-1:0]            limit;
  logic [CMP_W-1:0]            maxp_ext;
  logic                        at_limit;
  logic                        wr_en;
  logic [IDX_W-1:0]            wr_idx;
  logic [TW-1:0]               wr_data;

  assign clr       = (user_r != last_user_r) || (tick_r < last_tick_r);
  assign held_eff  = held_r & ~clr;
  assign block_eff = block_r & ~clr;
  assign rd_go     = cmd.scan && (rd_idx_r != count_r);

  assign win_eff   = (window_ticks == '0) ? WIN_W_L'(1) : window_ticks;
  assign age       = {1'b0, tick_r} - {1'b0, rdata_r};
  assign keep      = age[TW] || (age[TW-1:0] < {{(TW - WIN_W_L){1'b0}}, win_eff});

  assign maxp_ext  = CMP_W'(max_presses);
  assign limit     = (maxp_ext > CMP_W'(MAX_TRACKED)) ? CMP_W'(MAX_TRACKED) : maxp_ext;
  assign at_limit  = CMP_W'(kept_r) >= limit;

  assign sts.need_scan = ~exempt_r & guard_enable & down_r & ~held_eff;
  assign sts.scan_done = (rd_idx_r == count_r) && !cmp_vld_r;
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_button_out = obtn_r;
  assign out_suppressed = osup_r;

  always_comb begin
    count_nxt     = count_r;
    last_tick_nxt = last_tick_r;
    last_user_nxt = last_user_r;
    held_nxt      = held_r;
    block_nxt     = block_r;
    rd_idx_nxt    = rd_idx_r;
    kept_nxt      = kept_r;
    cmp_vld_nxt   = cmp_vld_r;
    res_btn_nxt   = res_btn_r;
    res_sup_nxt   = res_sup_r;
    wr_en         = 1'b0;
    wr_idx        = kept_r[IDX_W-1:0];
    wr_data       = rdata_r;

    if (cmd.eval) begin
      rd_idx_nxt  = '0;
      kept_nxt    = '0;
      cmp_vld_nxt = 1'b0;
      res_btn_nxt = down_r;
      res_sup_nxt = 1'b0;
      if (exempt_r) begin
        res_btn_nxt = down_r;
      end else if (!guard_enable) begin
        count_nxt     = '0;
        last_tick_nxt = '0;
        last_user_nxt = '0;
        held_nxt      = 1'b0;
        block_nxt     = 1'b0;
      end else begin
        last_tick_nxt = tick_r;
        last_user_nxt = user_r;
        count_nxt     = clr ? '0 : count_r;
        if (!down_r) begin
          held_nxt    = 1'b0;
          block_nxt   = 1'b0;
          res_btn_nxt = 1'b0;
        end else if (held_eff) begin
          held_nxt    = 1'b1;
          block_nxt   = block_eff;
          res_btn_nxt = ~block_eff;
          res_sup_nxt = block_eff;
        end
      end
    end

    if (cmd.scan) begin
      cmp_vld_nxt = rd_go;
      if (rd_go) begin
        rd_idx_nxt = rd_idx_r + CNT_W'(1);
      end
      if (cmp_vld_r && keep) begin
        wr_en    = 1'b1;
        wr_data  = rdata_r;
        kept_nxt = kept_r + CNT_W'(1);
      end
    end

    if (cmd.commit) begin
      held_nxt = 1'b1;
      if (at_limit) begin
        count_nxt   = kept_r;
        block_nxt   = 1'b1;
        res_btn_nxt = 1'b0;
        res_sup_nxt = 1'b1;
      end else begin
        wr_en       = 1'b1;
        wr_data     = tick_r;
        count_nxt   = kept_r + CNT_W'(1);
        block_nxt   = 1'b0;
        res_btn_nxt = 1'b1;
        res_sup_nxt = 1'b0;
      end
    end

    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      last_tick_r <= '0;
      last_user_r <= '0;
      held_r      <= 1'b0;
      block_r     <= 1'b0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      last_tick_r <= last_tick_nxt;
      last_user_r <= last_user_nxt;
      held_r      <= held_nxt;
      block_r     <= block_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      tick_r   <= in_tick;
      user_r   <= in_user_id;
      exempt_r <= in_exempt;
      down_r   <= in_button_down;
    end
    rd_idx_r  <= rd_idx_nxt;
    kept_r    <= kept_nxt;
    res_btn_r <= res_btn_nxt;
    res_sup_r <= res_sup_nxt;
    if (cmd.emit) begin
      obtn_r <= res_btn_nxt;
      osup_r <= res_sup_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      press_times_r[wr_idx] <= wr_data;
    end
    if (rd_go) begin
      rdata_r <= press_times_r[rd_idx_r[IDX_W-1:0]];
    end
  end

endmodule
